### src/aabb_frustum_cull_defines.svh
// ----------------------------------------------------------------------------
// AABB frustum cull assertion macros
// Concurrent checks on clk with synchronous active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define AFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aabb_frustum_cull: same-cycle check failed");
// Next-cycle implication
`define AFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aabb_frustum_cull: next-cycle check failed");
`else
`define AFC_ASSERT_NOW(lbl, ante, cons)
`define AFC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/afc_pkg.sv
// ----------------------------------------------------------------------------
// AABB frustum cull package
// Widths, plane register layout, payload types and class codes.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int SECTION_WIDTH = 16;
  localparam int NUM_PLANES    = 6;
  localparam int NUM_AXES      = 3;
  localparam int HEIGHT_W      = 13;
  localparam int NORM_W        = 12;
  localparam int OFFS_W        = 28;
  localparam int D_SHIFT       = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  // Box corner coordinates: x/z span SECTION_WIDTH*(sx+1), y spans h*(sy+1)
  localparam int XZ_W  = 17 + $clog2(SECTION_WIDTH + 1);
  localparam int Y_W   = 22;
  localparam int CW    = (XZ_W > Y_W) ? XZ_W : Y_W;
  localparam int PW    = CW + NORM_W;
  localparam int DW    = OFFS_W + D_SHIFT;
  localparam int SUM_W = ((PW > DW) ? PW : DW) + 2;

  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_HEIGHT = CFG_IDX_W'(NUM_PLANES);
  localparam logic [HEIGHT_W-1:0]   HEIGHT_RESET   = HEIGHT_W'(16);

  typedef enum logic [1:0] {
    CLASS_OUTSIDE   = 2'd0,
    CLASS_INTERSECT = 2'd1,
    CLASS_INSIDE    = 2'd2
  } cull_class_t;

  typedef struct packed {
    logic signed [OFFS_W-1:0] d;
    logic signed [NORM_W-1:0] nz;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic signed [15:0] section_x;
    logic signed [7:0]  section_y;
    logic signed [15:0] section_z;
  } in_t;

  typedef struct packed {
    cull_class_t cull_class;
    logic        visible;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] lo_x;
    logic signed [CW-1:0] hi_x;
    logic signed [CW-1:0] lo_y;
    logic signed [CW-1:0] hi_y;
    logic signed [CW-1:0] lo_z;
    logic signed [CW-1:0] hi_z;
  } box_t;

endpackage

### src/aabb_frustum_cull.sv
// ----------------------------------------------------------------------------
// AABB frustum cull
// Classifies one world section box against six frustum planes (p/n vertex).
// ----------------------------------------------------------------------------
//  Channel | Ports                                | Transfer
//  --------+--------------------------------------+---------------------------
//  input   | in_valid, in_ready, in_data (in_t)   | valid & ready at clk edge
//  result  | out_valid, out_ready, out_data       | valid & ready at clk edge
//  config  | cfg_we, cfg_index, cfg_data          | cfg_we at clk edge
//
//  One transaction per cycle sustained while out_ready stays high. From input
//  acceptance to out_valid it passes the input reg, box, plane products, plane
//  signs and output reg stages. The product stage with its 36 narrow
//  multipliers sets the cycle. Each stage holds only when it is full and the
//  stage after it holds, so bubbles are squeezed out. Reset clears all valid
//  bits, the planes to zero and the section height to 16.
// ----------------------------------------------------------------------------
`include "aabb_frustum_cull_defines.svh"

module aabb_frustum_cull
  import afc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration
  plane_t              plane_r [NUM_PLANES];
  logic [HEIGHT_W-1:0] height_r;

  // Stage valids and enables
  logic v_a_r, v_b_r, v_c_r, v_d_r, out_valid_r;
  logic en_a, en_b, en_c, en_d, en_o;

  // Stage payloads
  in_t                    a_r;
  box_t                   b_r, b_nxt;
  logic signed [PW-1:0]   prod_p_r   [NUM_PLANES][NUM_AXES];
  logic signed [PW-1:0]   prod_n_r   [NUM_PLANES][NUM_AXES];
  logic signed [PW-1:0]   prod_p_nxt [NUM_PLANES][NUM_AXES];
  logic signed [PW-1:0]   prod_n_nxt [NUM_PLANES][NUM_AXES];
  logic [NUM_PLANES-1:0]  neg_p_r, neg_n_r, neg_p_nxt, neg_n_nxt;
  out_t                   out_r, out_nxt;

  logic signed [CW-1:0] h_ext;

  assign en_o = !out_valid_r || out_ready;
  assign en_d = !v_d_r || en_o;
  assign en_c = !v_c_r || en_d;
  assign en_b = !v_b_r || en_c;
  assign en_a = !v_a_r || en_b;

  assign in_ready  = en_a;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration writes; out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_r[i] <= '0;
      end
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_HEIGHT) begin
        plane_r[cfg_index] <= plane_t'(cfg_data);
      end else if (cfg_index == CFG_IDX_HEIGHT) begin
        height_r <= cfg_data[HEIGHT_W-1:0];
      end
    end
  end

  // Stage B: box corners
  always_comb begin
    h_ext      = CW'(height_r);
    b_nxt.lo_x = CW'(a_r.section_x) * CW'(SECTION_WIDTH);
    b_nxt.hi_x = b_nxt.lo_x + CW'(SECTION_WIDTH);
    b_nxt.lo_y = CW'(a_r.section_y) * h_ext;
    b_nxt.hi_y = b_nxt.lo_y + h_ext;
    b_nxt.lo_z = CW'(a_r.section_z) * CW'(SECTION_WIDTH);
    b_nxt.hi_z = b_nxt.lo_z + CW'(SECTION_WIDTH);
  end

  // Stage C: per-plane products at the p and n vertices
  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      prod_p_nxt[i][0] = PW'(plane_r[i].nx) *
                         PW'((plane_r[i].nx > 0) ? b_r.hi_x : b_r.lo_x);
      prod_n_nxt[i][0] = PW'(plane_r[i].nx) *
                         PW'((plane_r[i].nx > 0) ? b_r.lo_x : b_r.hi_x);
      prod_p_nxt[i][1] = PW'(plane_r[i].ny) *
                         PW'((plane_r[i].ny > 0) ? b_r.hi_y : b_r.lo_y);
      prod_n_nxt[i][1] = PW'(plane_r[i].ny) *
                         PW'((plane_r[i].ny > 0) ? b_r.lo_y : b_r.hi_y);
      prod_p_nxt[i][2] = PW'(plane_r[i].nz) *
                         PW'((plane_r[i].nz > 0) ? b_r.hi_z : b_r.lo_z);
      prod_n_nxt[i][2] = PW'(plane_r[i].nz) *
                         PW'((plane_r[i].nz > 0) ? b_r.lo_z : b_r.hi_z);
    end
  end

  // Stage D: plane value signs
  always_comb begin
    logic signed [SUM_W-1:0] d_al;
    logic signed [SUM_W-1:0] sum_p;
    logic signed [SUM_W-1:0] sum_n;
    for (int i = 0; i < NUM_PLANES; i++) begin
      d_al  = SUM_W'(plane_r[i].d) <<< D_SHIFT;
      sum_p = SUM_W'(prod_p_r[i][0]) + SUM_W'(prod_p_r[i][1]) +
              SUM_W'(prod_p_r[i][2]) + d_al;
      sum_n = SUM_W'(prod_n_r[i][0]) + SUM_W'(prod_n_r[i][1]) +
              SUM_W'(prod_n_r[i][2]) + d_al;
      neg_p_nxt[i] = sum_p[SUM_W-1];
      neg_n_nxt[i] = sum_n[SUM_W-1];
    end
  end

  // Output: any rejecting plane wins, then any cutting plane
  always_comb begin
    priority if (|neg_p_r) begin
      out_nxt.cull_class = CLASS_OUTSIDE;
    end else if (|neg_n_r) begin
      out_nxt.cull_class = CLASS_INTERSECT;
    end else begin
      out_nxt.cull_class = CLASS_INSIDE;
    end
    out_nxt.visible = ~(|neg_p_r);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_c_r       <= 1'b0;
      v_d_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) v_a_r       <= in_valid;
      if (en_b) v_b_r       <= v_a_r;
      if (en_c) v_c_r       <= v_b_r;
      if (en_d) v_d_r       <= v_c_r;
      if (en_o) out_valid_r <= v_d_r;
    end
  end

  // Payload, advanced with the matching valid bit
  always_ff @(posedge clk) begin
    if (en_a) a_r <= in_data;
    if (en_b) b_r <= b_nxt;
    if (en_c) begin
      prod_p_r <= prod_p_nxt;
      prod_n_r <= prod_n_nxt;
    end
    if (en_d) begin
      neg_p_r <= neg_p_nxt;
      neg_n_r <= neg_n_nxt;
    end
    if (en_o) out_r <= out_nxt;
  end

  `AFC_ASSERT_NEXT(a_in_enters_pipe, in_valid && in_ready, v_a_r)
  `AFC_ASSERT_NEXT(a_sign_to_out, v_d_r && en_o, out_valid_r)
  `AFC_ASSERT_NOW(a_visible_class, out_valid_r,
                  out_r.visible == (out_r.cull_class != CLASS_OUTSIDE))
  `AFC_ASSERT_NEXT(a_stall_holds_d, v_d_r && !en_d, v_d_r && $stable(neg_p_r))

endmodule
